// ----- rtl/bsfd_pkg.sv -----
// Shared types and constants for the batch slot fill/drain buffer.
// No dependencies; imported by the top level.
package bsfd_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int TYPE_LIMIT_DEF = 28;

    localparam int TYPE_W   = 5;
    localparam int OFFSET_W = 58;
    localparam int COUNT_W  = 32;
    localparam int FACTOR_W = 8;
    localparam int ENTRY_W  = TYPE_W + OFFSET_W;
    localparam int PROD_W   = COUNT_W + FACTOR_W;

    localparam int CFG_IDX_W = 2;

    localparam logic [FACTOR_W-1:0] ACT_FACTOR_RST   = 8'd10;
    localparam logic [FACTOR_W-1:0] DEACT_FACTOR_RST = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE       = 2'd0,
        CFG_ACT_FACTOR   = 2'd1,
        CFG_DEACT_FACTOR = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_REJECTED = 3'd2,
        ST_GIVEN    = 3'd3,
        ST_NOTHING  = 3'd4,
        ST_CHECKED  = 3'd5,
        ST_CLEARED  = 3'd6
    } status_t;

endpackage

// ----- rtl/bsfd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module bsfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/batch_slot_fill_drain_buffer_top.sv -----
// Top level of the batch slot fill/drain buffer.
// Depends on bsfd_pkg and instantiates bsfd_ram for the slot store.

// Batch slot buffer with hysteresis gating. Each command on the slave stream
// (tuser = command) produces exactly one result on the master stream
// (tuser = status, tlast = finished). Adds fill a SLOT_COUNT-deep store; the
// add that fills the last slot starts drain mode, and gets then return the
// entries in order, the last one with tlast set, after which the store is
// empty again. Adds and gets are gated by the enable register and by the
// active flag, which the check command sets when left*activate_factor <
// total and clears when left*deactivate_factor > total (clearing wins).
// Clear empties the store and leaves drain mode regardless of enable.
// Add, check, clear and every rejected or empty get load the output register
// on acceptance; a get that returns an entry first reads the slot RAM, whose
// read data is registered, and loads its result in S_READ. One command is in
// flight at a time; a finished result sits in the output register so the next
// command can be accepted in the same cycle the result is transferred. There is
// no clearing pass after reset: the store is only read in drain mode, after
// every slot was written. Configuration writes are taken at any time but must
// only be issued while no command is in flight.
module batch_slot_fill_drain_buffer_top #(
    parameter int SLOT_COUNT = bsfd_pkg::SLOT_COUNT_DEF,
    parameter int TYPE_LIMIT = bsfd_pkg::TYPE_LIMIT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [4:0] entry_type, [62:5] entry_offset, [94:63] left_count,
    // [126:95] total_count, [127] zero
    input  logic [127:0]                      s_tdata,
    // [1:0] cmd
    input  logic [1:0]                        s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [4:0] out_type, [62:5] out_offset, [63] active_now
    output logic [63:0]                       m_tdata,
    // [2:0] status
    output logic [2:0]                        m_tuser,
    // finished
    output logic                              m_tlast,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [bsfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsfd_pkg::FACTOR_W-1:0]     cfg_data
);

    import bsfd_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int FW = $clog2(SLOT_COUNT + 1);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // input field unpacking
    logic [TYPE_W-1:0]   in_type;
    logic [OFFSET_W-1:0] in_offset;
    logic [COUNT_W-1:0]  in_left;
    logic [COUNT_W-1:0]  in_total;
    cmd_t                in_cmd;

    assign in_type   = s_tdata[4:0];
    assign in_offset = s_tdata[62:5];
    assign in_left   = s_tdata[94:63];
    assign in_total  = s_tdata[126:95];
    assign in_cmd    = cmd_t'(s_tuser);

    // control state
    state_t               state_reg, state_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [AW-1:0]        rpos_reg, rpos_next;
    logic                 drain_reg, drain_next;
    logic                 active_reg, active_next;
    logic                 last_reg, last_next;

    // configuration
    logic                 enable_reg;
    logic [FACTOR_W-1:0]  act_factor_reg;
    logic [FACTOR_W-1:0]  deact_factor_reg;

    // output register
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [TYPE_W-1:0]    m_type_reg, m_type_next;
    logic [OFFSET_W-1:0]  m_offset_reg, m_offset_next;
    logic                 m_fin_reg, m_fin_next;
    logic                 m_active_reg, m_active_next;

    // slot RAM
    logic                 ram_we;
    logic                 ram_re;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 accept;
    logic                 gate_ok;
    logic                 load;
    logic [FW-1:0]        fill_inc;
    logic [PROD_W-1:0]    act_prod;
    logic [PROD_W-1:0]    deact_prod;
    logic [PROD_W-1:0]    total_ext;

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign gate_ok  = enable_reg && active_reg;
    assign fill_inc = fill_reg + FW'(1);

    // hysteresis products: two independent narrow multiplies
    assign act_prod   = PROD_W'(in_left) * PROD_W'(act_factor_reg);
    assign deact_prod = PROD_W'(in_left) * PROD_W'(deact_factor_reg);
    assign total_ext  = PROD_W'(in_total);

    bsfd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata ({in_type, in_offset}),
        .re    (ram_re),
        .raddr (rpos_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        rpos_next     = rpos_reg;
        drain_next    = drain_reg;
        active_next   = active_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_type_next   = m_type_reg;
        m_offset_next = m_offset_reg;
        m_fin_next    = m_fin_reg;
        m_active_next = m_active_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        load          = 1'b0;

        // drop the result once it is transferred
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load          = 1'b1;
                    m_type_next   = TYPE_W'(TYPE_LIMIT);
                    m_offset_next = '0;
                    m_fin_next    = 1'b0;
                    unique case (in_cmd)
                        CMD_ADD:
                        begin
                            if (!gate_ok || drain_reg || (in_type >= TYPE_W'(TYPE_LIMIT)))
                            begin
                                m_status_next = ST_REJECTED;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                fill_next = fill_inc;
                                if (fill_inc == FW'(SLOT_COUNT))
                                begin
                                    rpos_next     = '0;
                                    drain_next    = 1'b1;
                                    m_status_next = ST_FULL;
                                end
                                else
                                begin
                                    m_status_next = ST_ADDED;
                                end
                            end
                        end
                        CMD_GET:
                        begin
                            if (!drain_reg || !gate_ok)
                            begin
                                m_status_next = ST_NOTHING;
                                m_fin_next    = 1'b1;
                            end
                            else
                            begin
                                // issue the read, finish the result next cycle
                                load       = 1'b0;
                                ram_re     = 1'b1;
                                state_next = S_READ;
                                // in drain mode the store is always full
                                if (rpos_reg == AW'(SLOT_COUNT - 1))
                                begin
                                    rpos_next  = '0;
                                    fill_next  = '0;
                                    drain_next = 1'b0;
                                    last_next  = 1'b1;
                                end
                                else
                                begin
                                    rpos_next = rpos_reg + AW'(1);
                                    last_next = 1'b0;
                                end
                            end
                        end
                        CMD_CHECK:
                        begin
                            if (enable_reg)
                            begin
                                if (act_prod < total_ext)
                                begin
                                    active_next = 1'b1;
                                end
                                if (deact_prod > total_ext)
                                begin
                                    active_next = 1'b0;
                                end
                            end
                            m_status_next = ST_CHECKED;
                        end
                        CMD_CLEAR:
                        begin
                            fill_next     = '0;
                            drain_next    = 1'b0;
                            m_status_next = ST_CLEARED;
                        end
                        default:
                        begin
                            m_status_next = ST_CLEARED;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                load          = 1'b1;
                m_status_next = ST_GIVEN;
                m_type_next   = ram_rdata[ENTRY_W-1 -: TYPE_W];
                m_offset_next = ram_rdata[OFFSET_W-1:0];
                m_fin_next    = last_reg;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            m_valid_next  = 1'b1;
            m_active_next = active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            rpos_reg         <= '0;
            drain_reg        <= 1'b0;
            active_reg       <= 1'b0;
            last_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_status_reg     <= ST_ADDED;
            m_type_reg       <= '0;
            m_offset_reg     <= '0;
            m_fin_reg        <= 1'b0;
            m_active_reg     <= 1'b0;
            enable_reg       <= 1'b0;
            act_factor_reg   <= ACT_FACTOR_RST;
            deact_factor_reg <= DEACT_FACTOR_RST;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            rpos_reg     <= rpos_next;
            drain_reg    <= drain_next;
            active_reg   <= active_next;
            last_reg     <= last_next;
            m_valid_reg  <= m_valid_next;
            m_status_reg <= m_status_next;
            m_type_reg   <= m_type_next;
            m_offset_reg <= m_offset_next;
            m_fin_reg    <= m_fin_next;
            m_active_reg <= m_active_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENABLE:       enable_reg       <= cfg_data[0];
                    CFG_ACT_FACTOR:   act_factor_reg   <= cfg_data;
                    CFG_DEACT_FACTOR: deact_factor_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_fin_reg;
    assign m_tdata  = {m_active_reg, m_offset_reg, m_type_reg};

    // drain mode only ever runs on a full store
    a_drain_full: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> (fill_reg == FW'(SLOT_COUNT)))
        else $error("drain mode with a partly filled store");

    // the read wait never overlaps a pending result
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !m_valid_reg)
        else $error("result register busy during store read");

    // the final get has already left drain mode when its data returns
    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_READ) && last_reg) |-> (!drain_reg && (rpos_reg == '0)))
        else $error("last entry given without ending drain");

    // a given entry always comes straight from a store read
    a_given_valid_type: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) && (m_status_reg == ST_GIVEN) |-> $past(state_reg == S_READ))
        else $error("entry given without a store read");

endmodule
